### sv/mfwq_pkg.sv
// ----------------------------------------------------------------------------
// mfwq_pkg
// Shared types and constants for the mutex with FIFO wait queue.
// ----------------------------------------------------------------------------
package mfwq_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    // Fixed result field widths
    localparam int STATUS_W    = 3;
    localparam int ID_OUT_W    = 8;
    localparam int COUNT_OUT_W = 5;
    localparam int CMD_W       = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_DONE     = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming command
        logic exec;   // apply the captured command to the lock state
    } ctl_t;

endpackage

### sv/mfwq_ctrl.sv
// ----------------------------------------------------------------------------
// mfwq_ctrl
// Sequencer: accepts a command, runs the execute state, raises the strobe.
// ----------------------------------------------------------------------------
module mfwq_ctrl
    import mfwq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

### sv/mfwq_dp.sv
// ----------------------------------------------------------------------------
// mfwq_dp
// Lock state, wait queue with per-entry compare and shift, result registers.
// ----------------------------------------------------------------------------
module mfwq_dp
    import mfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctl_t                      ctl,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [THREAD_ID_BITS-1:0] thread_id,
    input  logic                      no_wait,
    output logic [STATUS_W-1:0]       status,
    output logic                      owner_valid,
    output logic [ID_OUT_W-1:0]       owner_id,
    output logic                      woken_valid,
    output logic [ID_OUT_W-1:0]       woken_id,
    output logic [COUNT_OUT_W-1:0]    waiting_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TID_W = THREAD_ID_BITS;

    // Captured command
    logic [CMD_W-1:0] cmd_reg;
    logic [TID_W-1:0] tid_reg;
    logic             nowait_reg;

    // Lock state
    logic [TID_W-1:0] owner_reg, owner_next;
    logic             held_reg, held_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TID_W-1:0] q_reg  [QUEUE_DEPTH];
    logic [TID_W-1:0] q_next [QUEUE_DEPTH];
    logic [TID_W-1:0] q_up   [QUEUE_DEPTH];

    // Result registers
    status_t                 status_reg, status_next;
    logic                    owner_valid_reg;
    logic [ID_OUT_W-1:0]     owner_id_reg, owner_id_next;
    logic                    woken_valid_reg, woken_valid_next;
    logic [ID_OUT_W-1:0]     woken_id_reg, woken_id_next;
    logic [COUNT_OUT_W-1:0]  count_out_reg, count_out_next;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] after;
    logic                   waiting;
    logic                   full;
    logic                   empty;
    logic                   enq, pop, rm;
    logic [TID_W-1:0]       woken_tid;
    logic [31:0]            owner_w, woken_w, count_w;

    // Capture the command at accept
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= cmd;
            tid_reg    <= thread_id;
            nowait_reg <= no_wait;
        end
    end

    // Per-entry compare against the captured thread, valid below the fill count
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (q_reg[i] == tid_reg);
        end
    end

    // Entry at or beyond the matching slot moves down
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            after[i] = |(match & ((QUEUE_DEPTH)'(2) << i) - (QUEUE_DEPTH)'(1));
        end
    end

    // Queue shifted down by one slot
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            q_up[i] = q_reg[i + 1];
        end
        q_up[QUEUE_DEPTH-1] = q_reg[QUEUE_DEPTH-1];
    end

    assign waiting = |match;
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    // Command decode and lock update
    always_comb
    begin
        held_next   = held_reg;
        owner_next  = owner_reg;
        count_next  = count_reg;
        status_next = ST_REFUSED;
        woken_valid_next = 1'b0;
        woken_tid   = '0;
        enq         = 1'b0;
        pop         = 1'b0;
        rm          = 1'b0;
        case (cmd_reg)
            CMD_ACQUIRE:
            begin
                if (!held_reg)
                begin
                    held_next   = 1'b1;
                    owner_next  = tid_reg;
                    status_next = ST_ACQUIRED;
                end
                else if (nowait_reg || waiting)
                begin
                    status_next = ST_REFUSED;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    enq         = 1'b1;
                    count_next  = CNT_W'(count_reg + 1'b1);
                    status_next = ST_QUEUED;
                end
            end
            CMD_RELEASE:
            begin
                if (!empty)
                begin
                    owner_next       = q_reg[0];
                    held_next        = 1'b1;
                    woken_valid_next = 1'b1;
                    woken_tid        = q_reg[0];
                    pop              = 1'b1;
                    count_next       = CNT_W'(count_reg - 1'b1);
                end
                else
                begin
                    held_next  = 1'b0;
                    owner_next = '0;
                end
                status_next = ST_DONE;
            end
            CMD_TIMEOUT:
            begin
                woken_valid_next = 1'b1;
                woken_tid        = tid_reg;
                if (waiting)
                begin
                    rm         = 1'b1;
                    count_next = CNT_W'(count_reg - 1'b1);
                end
                status_next = ST_DONE;
            end
            default:
            begin
                status_next = ST_REFUSED;
            end
        endcase
    end

    // Queue entry update: shift, tail write or hold
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop || (rm && after[i]))
            begin
                q_next[i] = q_up[i];
            end
            else if (enq && (count_reg == CNT_W'(i)))
            begin
                q_next[i] = tid_reg;
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
    end

    // Result fields at their fixed widths
    assign owner_w        = held_next ? 32'(owner_next) : 32'd0;
    assign woken_w        = 32'(woken_tid);
    assign count_w        = 32'(count_next);
    assign owner_id_next  = owner_w[ID_OUT_W-1:0];
    assign woken_id_next  = woken_w[ID_OUT_W-1:0];
    assign count_out_next = count_w[COUNT_OUT_W-1:0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            count_reg <= count_next;
        end
    end

    // Queue storage and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
            status_reg      <= status_next;
            owner_valid_reg <= held_next;
            owner_id_reg    <= owner_id_next;
            woken_valid_reg <= woken_valid_next;
            woken_id_reg    <= woken_id_next;
            count_out_reg   <= count_out_next;
        end
    end

    assign status        = status_reg;
    assign owner_valid   = owner_valid_reg;
    assign owner_id      = owner_id_reg;
    assign woken_valid   = woken_valid_reg;
    assign woken_id      = woken_id_reg;
    assign waiting_count = count_out_reg;

endmodule

### sv/mutex_fifo_wait_queue_top.sv
// ----------------------------------------------------------------------------
// mutex_fifo_wait_queue_top
// Hardware mutex with a FIFO wait queue of thread IDs.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       cmd, thread_id, no_wait
//  result    done (1 cycle)     status, owner_valid, owner_id, woken_valid,
//                               woken_id, waiting_count
//
// A command transfers when start is high and busy is low; busy is then high
// for one execute cycle, and done strobes in the cycle after it, following
// the capture and execute steps of the sequencer. A new start may be taken
// in the cycle that done is high.
// Queue search, removal and shift act on all entries in the execute cycle.
// Reset leaves the lock free and the queue empty. Results cannot be stalled.
// ----------------------------------------------------------------------------
module mutex_fifo_wait_queue_top
    import mfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [THREAD_ID_BITS-1:0] thread_id,
    input  logic                      no_wait,
    output logic                      done,
    output logic [STATUS_W-1:0]       status,
    output logic                      owner_valid,
    output logic [ID_OUT_W-1:0]       owner_id,
    output logic                      woken_valid,
    output logic [ID_OUT_W-1:0]       woken_id,
    output logic [COUNT_OUT_W-1:0]    waiting_count
);

    ctl_t ctl;

    // Sequencer
    mfwq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // Lock and queue datapath
    mfwq_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cmd           (cmd),
        .thread_id     (thread_id),
        .no_wait       (no_wait),
        .status        (status),
        .owner_valid   (owner_valid),
        .owner_id      (owner_id),
        .woken_valid   (woken_valid),
        .woken_id      (woken_id),
        .waiting_count (waiting_count)
    );

endmodule

### sv/mfwq_checker.sv
// ----------------------------------------------------------------------------
// mfwq_checker
// Port-level checks of command/result timing and result consistency.
// ----------------------------------------------------------------------------
module mfwq_checker
    import mfwq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [STATUS_W-1:0]       status,
    input logic                      owner_valid,
    input logic [ID_OUT_W-1:0]       owner_id,
    input logic                      woken_valid,
    input logic [ID_OUT_W-1:0]       woken_id,
    input logic [COUNT_OUT_W-1:0]    waiting_count
);

    // Accepted command goes busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // Every execute cycle is followed by a result, with busy dropped
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("no result after execute cycle");

    // A result only follows an execute cycle
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a command");

    // Free lock reports no owner, and no wakeup reports no thread
    a_free_owner: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (owner_valid || owner_id == '0) && (woken_valid || woken_id == '0))
        else $error("id set without its valid flag");

    // Queue fill never exceeds its depth and status is a known code
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(waiting_count) <= QUEUE_DEPTH) && (status <= ST_FULL))
        else $error("waiting count above queue depth or unknown status");

endmodule

bind mutex_fifo_wait_queue_top mfwq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mfwq_checker (.*);
